// ===== rtl/wsd_pkg.sv =====
// Package: shared types, codes and helpers for the WebSocket frame deframer.
`timescale 1ns / 1ps
package wsd_pkg;

  localparam int CFG_W = 20;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 20'd4096;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [2:0] KIND_TEXT  = 3'd0;
  localparam logic [2:0] KIND_BIN   = 3'd1;
  localparam logic [2:0] KIND_CLOSE = 3'd2;
  localparam logic [2:0] KIND_PING  = 3'd3;
  localparam logic [2:0] KIND_PONG  = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_BAD_CONT = 2'd2;
  localparam logic [1:0] ERR_BAD_OP   = 2'd3;

  localparam logic [1:0] PREV_NONE = 2'd0;
  localparam logic [1:0] PREV_TEXT = 2'd1;
  localparam logic [1:0] PREV_BIN  = 2'd2;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] HDR_CNT_EXT16 = 3'd2;
  localparam logic [2:0] HDR_CNT_EXT64 = 3'd0;  // counts down through 8 bytes
  localparam logic [2:0] HDR_CNT_KEY   = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic [2:0] kind;
    logic       final_fragment;
    logic       last;
    logic [1:0] error;
  } result_t;

  typedef struct packed {
    logic has_result;
    logic dead;
  } parse_status_t;

  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] k;
    case (op)
      OP_TEXT:  k = KIND_TEXT;
      OP_BIN:   k = KIND_BIN;
      OP_CLOSE: k = KIND_CLOSE;
      OP_PING:  k = KIND_PING;
      default:  k = KIND_PONG;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/wsd_in_stage.sv =====
// Input register stage: holds one received byte until the parser consumes it.
`timescale 1ns / 1ps
module wsd_in_stage
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       step,
  output logic       in_valid,
  output logic [7:0] in_byte
);

  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

endmodule

// ===== rtl/wsd_parser.sv =====
// Frame parser: header state machine, length check, payload unmasking.
`timescale 1ns / 1ps
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int PAYLOAD_COUNT_WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic             step,
  input  logic [CFG_W-1:0] max_len,
  output parse_status_t    status,
  output result_t          result
);

  localparam int CNT_W = (PAYLOAD_COUNT_WIDTH < CFG_W) ? PAYLOAD_COUNT_WIDTH : CFG_W;
  localparam logic [CFG_W-1:0] CNT_MAX = CFG_W'({CNT_W{1'b1}});

  phase_t           phase, phase_next;
  logic             dead, dead_next;
  logic             fin, fin_next;
  logic [3:0]       op, op_next;
  logic [2:0]       kind, kind_next;
  logic             masked, masked_next;
  logic [CNT_W-1:0] len, len_next;
  logic             len_over, len_over_next;
  logic [2:0]       hdr_cnt, hdr_cnt_next;
  logic [31:0]      mask_key, mask_key_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic [1:0]       key_index, key_index_next;
  logic [1:0]       prev_kind, prev_kind_next;

  logic [CNT_W+7:0] shift_wide;
  logic [CNT_W-1:0] ext_len;
  logic             ext_over;
  logic [2:0]       cnt_dec;
  logic [CNT_W-1:0] hd_len;
  logic             hd_over;
  logic             hd_fire;
  logic             hd_empty;
  logic [CFG_W-1:0] limit;
  logic [3:0]       op_final;
  logic [1:0]       hd_err;
  logic [7:0]       key_byte;

  // Header completion: length selection, limit check, opcode resolution.
  always_comb begin
    shift_wide = {len, in_byte};
    ext_len    = shift_wide[CNT_W-1:0];
    ext_over   = len_over || (shift_wide[CNT_W+7:CNT_W] != 8'd0);
    cnt_dec    = hdr_cnt - 3'd1;

    case (phase)
      PH_HDR1: begin
        hd_len  = CNT_W'(in_byte[6:0]);
        hd_over = 1'b0;
        hd_fire = (in_byte[6:0] != LEN7_EXT16) && (in_byte[6:0] != LEN7_EXT64) && !in_byte[7];
      end
      PH_EXTLEN: begin
        hd_len  = ext_len;
        hd_over = ext_over;
        hd_fire = (cnt_dec == 3'd0) && !masked;
      end
      PH_KEY: begin
        hd_len  = len;
        hd_over = len_over;
        hd_fire = (cnt_dec == 3'd0);
      end
      default: begin
        hd_len  = len;
        hd_over = len_over;
        hd_fire = 1'b0;
      end
    endcase

    limit    = (max_len > CNT_MAX) ? CNT_MAX : max_len;
    op_final = op;
    hd_err   = ERR_NONE;
    if (hd_over || (CFG_W'(hd_len) > limit)) begin
      hd_err = ERR_TOO_LONG;
    end else if (op == OP_CONT) begin
      if (prev_kind == PREV_TEXT) begin
        op_final = OP_TEXT;
      end else if (prev_kind == PREV_BIN) begin
        op_final = OP_BIN;
      end else begin
        hd_err = ERR_BAD_CONT;
      end
    end
    if ((hd_err == ERR_NONE) &&
        !(op_final inside {OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG})) begin
      hd_err = ERR_BAD_OP;
    end
    hd_empty = (hd_len == '0);
  end

  // Next state.
  always_comb begin
    phase_next = phase;
    dead_next  = dead;
    if (hd_fire) begin
      phase_next = ((hd_err != ERR_NONE) || hd_empty) ? PH_HDR0 : PH_PAYLOAD;
      dead_next  = (hd_err != ERR_NONE);
    end else begin
      case (phase)
        PH_HDR0: phase_next = PH_HDR1;
        // extended length bytes come before the key
        PH_HDR1: phase_next = ((in_byte[6:0] == LEN7_EXT16) || (in_byte[6:0] == LEN7_EXT64)) ?
                              PH_EXTLEN : PH_KEY;
        PH_EXTLEN: begin
          if (cnt_dec == 3'd0) begin
            phase_next = PH_KEY;
          end
        end
        PH_KEY: phase_next = PH_KEY;
        PH_PAYLOAD: begin
          if (remaining == CNT_W'(1)) begin
            phase_next = PH_HDR0;
          end
        end
        default: phase_next = PH_HDR0;
      endcase
    end
  end

  // Datapath updates and the result for the byte at hand.
  always_comb begin
    fin_next       = fin;
    op_next        = op;
    kind_next      = kind;
    masked_next    = masked;
    len_next       = len;
    len_over_next  = len_over;
    hdr_cnt_next   = hdr_cnt;
    mask_key_next  = mask_key;
    remaining_next = remaining;
    key_index_next = key_index;
    prev_kind_next = prev_kind;
    key_byte       = mask_key[{~key_index, 3'b000} +: 8];
    status.has_result = 1'b0;
    status.dead       = dead;
    result         = '0;

    case (phase)
      PH_HDR0: begin
        fin_next = in_byte[7];
        op_next  = in_byte[3:0];
      end
      PH_HDR1: begin
        masked_next   = in_byte[7];
        mask_key_next = 32'd0;
        len_next      = CNT_W'(in_byte[6:0]);
        len_over_next = 1'b0;
        if (in_byte[6:0] == LEN7_EXT16) begin
          hdr_cnt_next = HDR_CNT_EXT16;
          len_next     = '0;
        end else if (in_byte[6:0] == LEN7_EXT64) begin
          hdr_cnt_next = HDR_CNT_EXT64;
          len_next     = '0;
        end else if (in_byte[7]) begin
          hdr_cnt_next = HDR_CNT_KEY;
        end
      end
      PH_EXTLEN: begin
        len_next      = ext_len;
        len_over_next = ext_over;
        hdr_cnt_next  = (cnt_dec == 3'd0) ? HDR_CNT_KEY : cnt_dec;
      end
      PH_KEY: begin
        mask_key_next = {mask_key[23:0], in_byte};
        hdr_cnt_next  = cnt_dec;
      end
      PH_PAYLOAD: begin
        key_index_next        = key_index + 2'd1;
        remaining_next        = remaining - CNT_W'(1);
        status.has_result     = !dead;
        result.data           = in_byte ^ key_byte;
        result.data_valid     = 1'b1;
        result.kind           = kind;
        result.final_fragment = fin;
        result.last           = (remaining == CNT_W'(1));
      end
      default: ;
    endcase

    if (hd_fire) begin
      if (hd_err != ERR_NONE) begin
        status.has_result = !dead;
        result.last       = 1'b1;
        result.error      = hd_err;
      end else begin
        op_next        = op_final;
        kind_next      = kind_of(op_final);
        remaining_next = hd_len;
        key_index_next = 2'd0;
        if (op_final == OP_TEXT) begin
          prev_kind_next = PREV_TEXT;
        end else if (op_final == OP_BIN) begin
          prev_kind_next = PREV_BIN;
        end
        if (hd_empty) begin
          status.has_result     = !dead;
          result.kind           = kind_of(op_final);
          result.final_fragment = fin;
          result.last           = 1'b1;
        end
      end
    end
  end

  // A dead session consumes bytes without touching any state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      dead      <= 1'b0;
      hdr_cnt   <= 3'd0;
      remaining <= '0;
      key_index <= 2'd0;
      prev_kind <= PREV_NONE;
    end else if (step && in_valid && !dead) begin
      phase     <= phase_next;
      dead      <= dead_next;
      hdr_cnt   <= hdr_cnt_next;
      remaining <= remaining_next;
      key_index <= key_index_next;
      prev_kind <= prev_kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_valid && !dead) begin
      fin      <= fin_next;
      op       <= op_next;
      kind     <= kind_next;
      masked   <= masked_next;
      len      <= len_next;
      len_over <= len_over_next;
      mask_key <= mask_key_next;
    end
  end

endmodule

// ===== rtl/wsd_out_stage.sv =====
// Result register: holds one result until the downstream transaction completes.
`timescale 1ns / 1ps
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    result,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [6:0] m_tuser
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= result.data;
      m_tlast <= result.last;
      m_tuser <= {result.error, result.final_fragment, result.kind, result.data_valid};
    end
  end

endmodule

// ===== rtl/websocket_frame_deframer_unit.sv =====
// Usage
//   s_* carries received bytes, one per transaction. m_* carries results:
//   unmasked payload bytes, an empty-frame marker or a single error result.
//   cfg_* writes max_payload_len (20 bits); cfg_ready is always high and the
//   register should only be written while no bytes are in flight.
// Throughput and data path
//   One byte per cycle sustained while results are taken. An accepted byte sits
//   in the input register and is then parsed into the result register, which
//   drives its result on m_*. Header bytes that end nothing give no result and
//   never wait on m_tready.
// Stall
//   While a result waits on m_tready, the input register still takes one
//   more byte; if that byte also makes a result, s_tready drops until the
//   waiting result transaction completes. Header bytes keep flowing.
// Reset
//   rst clears the parser to the first header byte, forgets the previous data
//   kind, clears the dead session and restores max_payload_len to 4096.
//   After an error result the block drops all further bytes until reset.
`timescale 1ns / 1ps
module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int PAYLOAD_COUNT_WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [7:0] data
  output logic             m_tlast,
  output logic [6:0]       m_tuser,   // [0] data_valid, [3:1] kind, [4] final_fragment,
                                      // [6:5] error
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             step;
  logic             load;
  logic [CFG_W-1:0] max_len;
  parse_status_t    status;
  result_t          result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= cfg_data;
    end
  end

  // Advance the held byte unless it makes a result and the output is full.
  assign step = in_valid && !(status.has_result && m_tvalid && !m_tready);
  assign load = step && status.has_result;

  wsd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .step     (step),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  wsd_parser #(
    .PAYLOAD_COUNT_WIDTH (PAYLOAD_COUNT_WIDTH)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .step     (step),
    .max_len  (max_len),
    .status   (status),
    .result   (result)
  );

  wsd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!m_tvalid || m_tready))
    else $error("result register loaded while a result is still pending");

  a_dead_sticky: assert property (@(posedge clk) disable iff (rst)
    status.dead |=> status.dead && !load)
    else $error("dead session resumed or produced a result");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[6:5] != ERR_NONE)) |-> (m_tlast && !m_tuser[0] && m_tdata == 8'd0))
    else $error("error result with payload or without last");

  a_empty_data_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 8'd0))
    else $error("no-data result without last or with nonzero data");

endmodule

// ===== tb/sv/websocket_frame_deframer_unit_test.sv =====
// Self-checking testbench for the WebSocket frame deframer: random frames, flow control, limits.
`timescale 1ns / 1ps
module websocket_frame_deframer_unit_test;
  import wsd_pkg::*;

  localparam int COUNT_W = 20;
  localparam int WATCHDOG_CYCLES = 5000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 6;
  localparam int MAX_REPORTS = 10;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  // Tracks the parser state and holds the results still owed by the block.
  class deframe_scoreboard;
    logic [CFG_W-1:0]   max_len;
    phase_t             ph;
    logic               fin;
    logic [3:0]         opcode;
    logic               masked;
    logic [63:0]        len_acc;
    logic [2:0]         hdr_left;
    logic [31:0]        key;
    logic [COUNT_W-1:0] remaining;
    logic [1:0]         key_idx;
    logic [1:0]         prev_kind;
    logic               dead;
    result_t            owed_q[$];
    int unsigned        mismatches;
    int unsigned        checked;

    function new();
      max_len = MAX_LEN_RESET;
      ph = PH_HDR0;
      fin = 1'b0;
      opcode = '0;
      masked = 1'b0;
      len_acc = '0;
      hdr_left = '0;
      key = '0;
      remaining = '0;
      key_idx = '0;
      prev_kind = PREV_NONE;
      dead = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_limit(input logic [CFG_W-1:0] v);
      max_len = v;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function logic [2:0] kind_for(input logic [3:0] op);
      case (op)
        OP_TEXT:  return KIND_TEXT;
        OP_BIN:   return KIND_BIN;
        OP_CLOSE: return KIND_CLOSE;
        OP_PING:  return KIND_PING;
        default:  return KIND_PONG;
      endcase
    endfunction

    function void queue_result(input logic [7:0] d, input logic dv, input logic [2:0] k,
                               input logic f, input logic l, input logic [1:0] e);
      result_t r;
      r.data = d;
      r.data_valid = dv;
      r.kind = k;
      r.final_fragment = f;
      r.last = l;
      r.error = e;
      owed_q.push_back(r);
    endfunction

    // Errors are decided only once the whole header has been seen.
    function void header_complete();
      logic [1:0] err;
      logic [3:0] op;
      err = ERR_NONE;
      op = opcode;
      if (len_acc > 64'(max_len)) begin
        err = ERR_TOO_LONG;
      end else if (op == OP_CONT) begin
        if (prev_kind == PREV_TEXT) op = OP_TEXT;
        else if (prev_kind == PREV_BIN) op = OP_BIN;
        else err = ERR_BAD_CONT;
      end
      if (err == ERR_NONE && !(op == OP_TEXT || op == OP_BIN || op == OP_CLOSE ||
                               op == OP_PING || op == OP_PONG)) begin
        err = ERR_BAD_OP;
      end
      if (err != ERR_NONE) begin
        dead = 1'b1;
        ph = PH_HDR0;
        queue_result('0, 1'b0, '0, 1'b0, 1'b1, err);
        return;
      end
      opcode = op;
      if (op == OP_TEXT) prev_kind = PREV_TEXT;
      else if (op == OP_BIN) prev_kind = PREV_BIN;
      remaining = len_acc[COUNT_W-1:0];
      key_idx = '0;
      if (remaining == '0) begin
        ph = PH_HDR0;
        queue_result('0, 1'b0, kind_for(op), fin, 1'b1, ERR_NONE);
      end else begin
        ph = PH_PAYLOAD;
      end
    endfunction

    function void note_byte(input logic [7:0] b);
      logic [7:0] kb;
      if (dead) return;
      case (ph)
        PH_HDR0: begin
          fin = b[7];
          opcode = b[3:0];
          ph = PH_HDR1;
        end
        PH_HDR1: begin
          masked = b[7];
          key = '0;
          len_acc = '0;
          if (b[6:0] == LEN7_EXT16) begin
            hdr_left = HDR_CNT_EXT16;
            ph = PH_EXTLEN;
          end else if (b[6:0] == LEN7_EXT64) begin
            hdr_left = HDR_CNT_EXT64;
            ph = PH_EXTLEN;
          end else begin
            len_acc = 64'(b[6:0]);
            if (masked) begin
              hdr_left = HDR_CNT_KEY;
              ph = PH_KEY;
            end else begin
              header_complete();
            end
          end
        end
        PH_EXTLEN: begin
          len_acc = {len_acc[55:0], b};
          hdr_left = hdr_left - 3'd1;
          if (hdr_left == 3'd0) begin
            if (masked) begin
              hdr_left = HDR_CNT_KEY;
              ph = PH_KEY;
            end else begin
              header_complete();
            end
          end
        end
        PH_KEY: begin
          key = {key[23:0], b};
          hdr_left = hdr_left - 3'd1;
          if (hdr_left == 3'd0) header_complete();
        end
        PH_PAYLOAD: begin
          // first key byte received is the most significant
          kb = key[(3 - int'(key_idx)) * 8 +: 8];
          key_idx = key_idx + 2'd1;
          remaining = remaining - COUNT_W'(1);
          queue_result(b ^ kb, 1'b1, kind_for(opcode), fin, remaining == '0, ERR_NONE);
          if (remaining == '0) ph = PH_HDR0;
        end
        default: ph = PH_HDR0;
      endcase
    endfunction

    function void check_result(input result_t got);
      result_t want;
      checked++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result data=%h dv=%b kind=%0d fin=%b last=%b err=%0d",
                   got.data, got.data_valid, got.kind, got.final_fragment, got.last, got.error);
        return;
      end
      want = owed_q.pop_front();
      if (got.data !== want.data || got.data_valid !== want.data_valid ||
          got.kind !== want.kind || got.final_fragment !== want.final_fragment ||
          got.last !== want.last || got.error !== want.error) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: result %0d expected data=%h dv=%b kind=%0d fin=%b last=%b err=%0d",
                   checked, want.data, want.data_valid, want.kind, want.final_fragment,
                   want.last, want.error);
          $display("       actual             data=%h dv=%b kind=%0d fin=%b last=%b err=%0d",
                   got.data, got.data_valid, got.kind, got.final_fragment, got.last,
                   got.error);
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [7:0]       m_tdata;
  logic             m_tlast;
  logic [6:0]       m_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  deframe_scoreboard sb;
  int unsigned bytes_in = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned cur_limit = 4096;
  int unsigned frames_sent = 0;
  int unsigned err_choice = 0;
  logic        data_seen = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  websocket_frame_deframer_unit #(
    .PAYLOAD_COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= dst_idle_pct);
    end
  end

  // Sample every transaction at the rising edge; the watchdog counts dead cycles.
  always @(posedge clk) begin : monitor_blk
    result_t got;
    logic    busy;
    busy = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_byte(s_tdata);
        bytes_in++;
        busy = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        got.data = m_tdata;
        got.data_valid = m_tuser[0];
        got.kind = m_tuser[3:1];
        got.final_fragment = m_tuser[4];
        got.last = m_tlast;
        got.error = m_tuser[6:5];
        sb.check_result(got);
        busy = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_limit(cfg_data);
        cfg_writes++;
        busy = 1'b1;
      end
    end
    idle_cycles = busy ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("ERROR: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("FAIL websocket_frame_deframer_unit");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned seen;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = 8'($urandom_range(255));
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    seen = bytes_in;
    do @(negedge clk); while (bytes_in == seen);
  endtask

  // Pause the sender until every owed result has come out.
  task automatic drain(input int unsigned settle);
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    int unsigned seen;
    drain(SETTLE);
    cfg_valid = 1'b1;
    cfg_data = v;
    seen = cfg_writes;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid = 1'b0;
    cur_limit = int'(v);
  endtask

  // RSV bits are never checked by the block, so fill them at random.
  task automatic send_frame(input logic [3:0] op, input logic fin, input logic masked,
                            input logic [63:0] len, input len_form_t form,
                            input logic [31:0] key, input int fill,
                            input int unsigned payload_bytes);
    send_byte({fin, 3'($urandom_range(7)), op});
    case (form)
      LEN_SHORT: send_byte({masked, len[6:0]});
      LEN_EXT16: begin
        send_byte({masked, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[i*8 +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[i*8 +: 8]);
    for (int unsigned i = 0; i < payload_bytes; i++)
      send_byte(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
    if (op == OP_TEXT || op == OP_BIN) data_seen = 1'b1;
    frames_sent++;
  endtask

  task automatic send_random_frame();
    logic [3:0]  op;
    int unsigned len;
    len_form_t   form;
    case ($urandom_range(5))
      0: op = OP_TEXT;
      1: op = OP_BIN;
      2: op = data_seen ? OP_CONT : OP_TEXT;
      3: op = OP_CLOSE;
      4: op = OP_PING;
      default: op = OP_PONG;
    endcase
    case ($urandom_range(39))
      0, 1, 2, 3: len = 0;
      4: len = $urandom_range(260, 126);
      5: len = 125;
      6, 7: len = (cur_limit <= 64) ? cur_limit : $urandom_range(64, 1);
      default: len = $urandom_range(10, 1);
    endcase
    // keep within the current limit; a too-long frame would end the session
    if (len > cur_limit) len = $urandom_range(cur_limit);
    if (len > 125) begin
      form = ($urandom_range(4) == 0) ? LEN_EXT64 : LEN_EXT16;
    end else begin
      case ($urandom_range(9))
        7, 8: form = LEN_EXT16;
        9: form = LEN_EXT64;
        default: form = LEN_SHORT;
      endcase
    end
    send_frame(op, 1'($urandom_range(1)), 1'($urandom_range(1)), 64'(len), form, $urandom,
               -1, len);
  endtask

  task automatic random_until(input int unsigned byte_mark);
    while (bytes_in < byte_mark) send_random_frame();
  endtask

  initial begin
    logic [3:0]  bad_op;
    int unsigned r;
    sb = new();
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    src_idle_pct = 8;
    dst_idle_pct = 45;
    // empty frame, masked binary with byte extremes, continuation, control frames
    send_frame(OP_TEXT, 1'b1, 1'b0, 64'd0, LEN_SHORT, '0, -1, 0);
    send_frame(OP_BIN, 1'b0, 1'b1, 64'd2, LEN_SHORT, 32'hFFFF_FFFF, 0, 2);
    send_frame(OP_CONT, 1'b1, 1'b0, 64'd1, LEN_SHORT, '0, 255, 1);
    send_frame(OP_CLOSE, 1'b1, 1'b0, 64'd1, LEN_EXT16, '0, -1, 1);
    send_frame(OP_PING, 1'b1, 1'b1, 64'd0, LEN_SHORT, $urandom, -1, 0);
    send_frame(OP_PONG, 1'b0, 1'b0, 64'd1, LEN_SHORT, '0, -1, 1);
    random_until(250);
    drain(0);
    random_until(400);

    src_idle_pct = 45;
    dst_idle_pct = 8;
    write_limit(20'hFFFFF);
    random_until(600);
    // stall the receiver while a long payload keeps coming
    hold_req = 1'b1;
    send_frame(OP_BIN, 1'b1, 1'b1, 64'd150, LEN_EXT16, $urandom, -1, 150);
    random_until(900);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    write_limit('0);
    random_until(980);
    write_limit(20'd7);
    random_until(1200);
    write_limit(20'($urandom_range(1048574, 64)));
    random_until(1500);

    // end the session with one error, then feed bytes that must be dropped
    err_choice = $urandom_range(2);
    case (err_choice)
      0: send_frame(OP_TEXT, 1'b1, 1'($urandom_range(1)), 64'(cur_limit) + 64'd1, LEN_EXT64,
                    $urandom, -1, 0);
      1: send_frame(4'($urandom_range(15)), 1'b1, 1'b0, {1'b1, 31'($urandom), 32'($urandom)},
                    LEN_EXT64, '0, -1, 0);
      default: begin
        r = $urandom_range(9);
        bad_op = (r < 5) ? 4'(3 + r) : 4'(6 + r);
        send_frame(bad_op, 1'($urandom_range(1)), 1'($urandom_range(1)), 64'd0, LEN_SHORT,
                   $urandom, -1, 0);
      end
    endcase
    repeat (16) send_byte(8'($urandom_range(255)));
    drain(SETTLE);

    $display("Covered %0d bytes in %0d frames, %0d results checked, %0d limit writes.",
             bytes_in, frames_sent, sb.checked, cfg_writes);
    $display("Closing error case %0d; flow control with idling both ways and a long stall.",
             err_choice);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS websocket_frame_deframer_unit");
    end else begin
      $display("ERROR: %0d mismatches, %0d results still owed", sb.mismatches, sb.pending());
      $display("FAIL websocket_frame_deframer_unit");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wsd_pkg.sv
rtl/wsd_in_stage.sv
rtl/wsd_parser.sv
rtl/wsd_out_stage.sv
rtl/websocket_frame_deframer_unit.sv
tb/sv/websocket_frame_deframer_unit_test.sv
